/* hw/rtl/s3f_pkg.sv */
// shared types, constants and codes of the s3-fifo replacement engine
package s3f_pkg;

    // ring geometry
    localparam int SMALL_DEPTH = 64;
    localparam int MAIN_DEPTH  = 256;
    localparam int GRING_DEPTH = 256;
    localparam int KEY_BITS    = 32;

    localparam int S_AW = $clog2(SMALL_DEPTH);
    localparam int M_AW = $clog2(MAIN_DEPTH);
    localparam int G_AW = $clog2(GRING_DEPTH);
    localparam int S_CW = $clog2(SMALL_DEPTH + 1);
    localparam int M_CW = $clog2(MAIN_DEPTH + 1);
    localparam int G_CW = $clog2(GRING_DEPTH + 1);
    localparam int SM_CW = (S_CW > M_CW) ? S_CW : M_CW;
    localparam int IDX_W = (SM_CW > G_CW) ? SM_CW : G_CW;

    // field widths
    localparam int SIZE_W = 16;
    localparam int CAP_W  = 16;
    localparam int OCC_W  = 17;
    localparam int FREQ_W = 2;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [FREQ_W-1:0] FREQ_MAX = 2'd3;
    localparam logic [FREQ_W-1:0] FREQ_ONE = 2'd1;

    // register reset values
    localparam logic [CAP_W-1:0]  SMALL_CAP_RST = 16'd100;
    localparam logic [CAP_W-1:0]  MAIN_CAP_RST  = 16'd900;
    localparam logic [CAP_W-1:0]  GHOST_CAP_RST = 16'd900;
    localparam logic [FREQ_W-1:0] PROMOTE_RST   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_CAP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE   = 2'd3;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ACCESS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   size;
        logic [FREQ_W-1:0]   freq;
    } slot_t;

    typedef enum logic [1:0] {
        Q_SMALL,
        Q_MAIN,
        Q_GHOST
    } q_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_FIND_INIT,
        OP_FIND_INIT_CUR,
        OP_READ_IDX,
        OP_READ_IDX1,
        OP_READ_HEAD,
        OP_IDX_INC,
        OP_BUMP,
        OP_REM_SUB,
        OP_REM_SHIFT,
        OP_REM_END,
        OP_POP,
        OP_POP_PROMOTE,
        OP_ROTATE_M,
        OP_GPUSH
    } dp_op_t;

    typedef enum logic [3:0] {
        C_ACC_S,
        C_ACC_G,
        C_ACC_M,
        C_PEEK_S,
        C_PEEK_M,
        C_REM_S,
        C_REM_G,
        C_REM_M,
        C_GPUT
    } ctx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_F_CHK,
        ST_F_CMP,
        ST_NOTFOUND,
        ST_FOUND,
        ST_BUMP,
        ST_R_SUB,
        ST_R_CHK,
        ST_R_WR,
        ST_R_END,
        ST_MISS,
        ST_LOOP_CHK,
        ST_EV_START,
        ST_EV_ONCE,
        ST_EM_LOOP,
        ST_EM_POP,
        ST_ES_LOOP,
        ST_ES_POP,
        ST_GP_START,
        ST_GP_DROP,
        ST_GP_POPG,
        ST_GP_PUSH,
        ST_EV_END,
        ST_INSERT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        q_sel_t q;
        logic   set_present;
        logic   set_ghost;
        logic   set_removed;
        logic   do_insert;
        logic   ev_begin;
        logic   ev_mark;
        logic   load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic       match;
        logic [2:0] idx_lt;
        logic [2:0] idx1_lt;
        logic       too_big;
        logic       loop_cond;
        logic       total_zero;
        logic       ev_main_sel;
        logic       s_empty;
        logic       m_empty;
        logic       promote;
        logic       freq_nz;
        logic       ghost_skip;
        logic       ghost_drop;
        logic       ev_again;
        logic       out_free;
    } status_t;

endpackage

/* hw/rtl/s3f_req_if.sv */
// request channel interface
interface s3f_req_if;
    import s3f_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [KEY_BITS-1:0] object_key;
    logic [SIZE_W-1:0]   object_size;
    modport source (output valid, kind, object_key, object_size, input ready);
    modport sink (input valid, kind, object_key, object_size, output ready);
endinterface

/* hw/rtl/s3f_rsp_if.sv */
// result channel interface
interface s3f_rsp_if;
    logic valid;
    logic ready;
    logic present;
    logic ghost_seen;
    logic admitted;
    logic placed_main;
    logic was_removed;
    modport source (output valid, present, ghost_seen, admitted, placed_main, was_removed,
                    input ready);
    modport sink (input valid, present, ghost_seen, admitted, placed_main, was_removed,
                  output ready);
endinterface

/* hw/rtl/s3f_cfg_if.sv */
// configuration write channel interface
interface s3f_cfg_if;
    import s3f_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/s3fifo_replacement_policy_unit.sv */
// top level of the s3-fifo replacement engine
// One request is handled at a time. A lookup walks its ring from the head, a registered read
// and then a compare per entry, and a miss of an access or removal scans small, ghost and
// main in turn. Removal shifts the tail of the ring down one entry at a time. Each eviction
// pop reads the ring head and then pops it, plus a ghost lookup over the ghost ring when an
// entry leaves small without promotion. The worst case is bounded by ring scans and eviction
// passes. The result sits in an output register, so the next request is taken while it waits.
// No clearing pass follows reset: ring contents beyond the fill counts are never read. Config
// writes are taken at once.
module s3fifo_replacement_policy_unit (
    input logic       clk,
    input logic       rst_n,
    s3f_req_if.sink   req,
    s3f_rsp_if.source rsp,
    s3f_cfg_if.sink   cfg
);
    import s3f_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg.ready = 1'b1;

    // sequencer
    s3f_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // rings, pointers and registers
    s3f_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .req_kind        (req.kind),
        .req_key         (req.object_key),
        .req_size        (req.object_size),
        .cfg_valid       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .rsp_valid       (rsp.valid),
        .rsp_ready       (rsp.ready),
        .rsp_present     (rsp.present),
        .rsp_ghost_seen  (rsp.ghost_seen),
        .rsp_admitted    (rsp.admitted),
        .rsp_placed_main (rsp.placed_main),
        .rsp_was_removed (rsp.was_removed)
    );

endmodule

/* hw/rtl/s3f_datapath.sv */
// datapath: rings, pointers, occupancy, config and result registers
module s3f_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  s3f_pkg::cmd_t                 cmd,
    output s3f_pkg::status_t              st,
    input  logic [s3f_pkg::KIND_W-1:0]    req_kind,
    input  logic [s3f_pkg::KEY_BITS-1:0]  req_key,
    input  logic [s3f_pkg::SIZE_W-1:0]    req_size,
    input  logic                          cfg_valid,
    input  logic [s3f_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [s3f_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic                          rsp_present,
    output logic                          rsp_ghost_seen,
    output logic                          rsp_admitted,
    output logic                          rsp_placed_main,
    output logic                          rsp_was_removed
);
    import s3f_pkg::*;

    // ring storage
    slot_t s_mem [SMALL_DEPTH];
    slot_t m_mem [MAIN_DEPTH];
    slot_t g_mem [GRING_DEPTH];

    logic [S_AW-1:0] s_head_reg;
    logic [M_AW-1:0] m_head_reg;
    logic [G_AW-1:0] g_head_reg;
    logic [S_CW-1:0] s_cnt_reg;
    logic [M_CW-1:0] m_cnt_reg;
    logic [G_CW-1:0] g_cnt_reg;
    logic [OCC_W-1:0] s_occ_reg;
    logic [OCC_W-1:0] m_occ_reg;
    logic [OCC_W-1:0] g_occ_reg;
    logic             ev_once_reg;

    logic [CAP_W-1:0]  s_cap_reg;
    logic [CAP_W-1:0]  m_cap_reg;
    logic [CAP_W-1:0]  g_cap_reg;
    logic [FREQ_W-1:0] thr_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [KEY_BITS-1:0] fkey_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [OCC_W:0]      before_reg;
    slot_t               cur_reg;
    logic                gh_reg;

    slot_t  rd_s_reg;
    slot_t  rd_m_reg;
    slot_t  rd_g_reg;
    q_sel_t rd_q_reg;
    slot_t  rd_slot;

    logic res_present_reg;
    logic res_ghost_reg;
    logic res_admitted_reg;
    logic res_main_reg;
    logic res_removed_reg;

    logic out_valid_reg;
    logic out_present_reg;
    logic out_ghost_reg;
    logic out_admitted_reg;
    logic out_main_reg;
    logic out_removed_reg;

    logic [IDX_W:0]   idx1;
    logic [IDX_W-1:0] roff;
    logic             rd_op;
    logic [S_AW-1:0]  s_raddr;
    logic [M_AW-1:0]  m_raddr;
    logic [G_AW-1:0]  g_raddr;
    logic             s_we;
    logic             m_we;
    logic             g_we;
    logic [S_AW-1:0]  s_waddr;
    logic [M_AW-1:0]  m_waddr;
    logic [G_AW-1:0]  g_waddr;
    slot_t            wdata;
    logic             s_full;
    logic             m_full;
    logic             g_full;
    logic             dq_main;
    logic             dq_full;
    logic [OCC_W:0]   total;
    logic [FREQ_W-1:0] freq_inc;

    assign idx1 = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
    assign s_full = (s_cnt_reg == S_CW'(SMALL_DEPTH));
    assign m_full = (m_cnt_reg == M_CW'(MAIN_DEPTH));
    assign g_full = (g_cnt_reg == G_CW'(GRING_DEPTH));
    assign total = {1'b0, s_occ_reg} + {1'b0, m_occ_reg};
    assign dq_main = gh_reg || (!ev_once_reg && (s_occ_reg >= OCC_W'(s_cap_reg)));
    assign dq_full = dq_main ? m_full : s_full;
    assign freq_inc = (rd_slot.freq == FREQ_MAX) ? FREQ_MAX : rd_slot.freq + FREQ_ONE;

    // registered read data of the ring last read
    always_comb
    begin
        case (rd_q_reg)
            Q_SMALL: rd_slot = rd_s_reg;
            Q_MAIN:  rd_slot = rd_m_reg;
            default: rd_slot = rd_g_reg;
        endcase
    end

    // read address
    always_comb
    begin
        rd_op = (cmd.op inside {OP_READ_IDX, OP_READ_IDX1, OP_READ_HEAD});
        case (cmd.op)
            OP_READ_IDX:  roff = idx_reg;
            OP_READ_IDX1: roff = idx1[IDX_W-1:0];
            default:      roff = '0;
        endcase
        s_raddr = s_head_reg + roff[S_AW-1:0];
        m_raddr = m_head_reg + roff[M_AW-1:0];
        g_raddr = g_head_reg + roff[G_AW-1:0];
    end

    // write port control
    always_comb
    begin
        s_we = 1'b0;
        m_we = 1'b0;
        g_we = 1'b0;
        s_waddr = s_head_reg + idx_reg[S_AW-1:0];
        m_waddr = m_head_reg + idx_reg[M_AW-1:0];
        g_waddr = g_head_reg + idx_reg[G_AW-1:0];
        wdata = rd_slot;
        if (cmd.do_insert)
        begin
            wdata = '{key: key_reg, size: size_reg, freq: '0};
            s_waddr = s_head_reg + s_cnt_reg[S_AW-1:0];
            m_waddr = m_head_reg + m_cnt_reg[M_AW-1:0];
            s_we = !dq_full && !dq_main;
            m_we = !dq_full && dq_main;
        end
        else
        begin
            case (cmd.op)
                OP_BUMP, OP_REM_SHIFT:
                begin
                    if (cmd.op == OP_BUMP)
                        wdata.freq = freq_inc;
                    s_we = (cmd.q == Q_SMALL);
                    m_we = (cmd.q == Q_MAIN);
                    g_we = (cmd.q == Q_GHOST);
                end
                OP_POP_PROMOTE:
                begin
                    wdata.freq = '0;
                    m_waddr = m_head_reg + m_cnt_reg[M_AW-1:0];
                    m_we = 1'b1;
                end
                OP_ROTATE_M:
                begin
                    wdata.freq = rd_slot.freq - FREQ_ONE;
                    m_waddr = m_head_reg + m_cnt_reg[M_AW-1:0];
                    m_we = 1'b1;
                end
                OP_GPUSH:
                begin
                    wdata = cur_reg;
                    wdata.freq = '0;
                    g_waddr = g_head_reg + g_cnt_reg[G_AW-1:0];
                    g_we = 1'b1;
                end
                default:
                begin
                    s_we = 1'b0;
                end
            endcase
        end
    end

    // small ring memory
    always_ff @(posedge clk)
    begin
        if (s_we)
            s_mem[s_waddr] <= wdata;
        if (rd_op && (cmd.q == Q_SMALL))
            rd_s_reg <= s_mem[s_raddr];
    end

    // main ring memory
    always_ff @(posedge clk)
    begin
        if (m_we)
            m_mem[m_waddr] <= wdata;
        if (rd_op && (cmd.q == Q_MAIN))
            rd_m_reg <= m_mem[m_raddr];
    end

    // ghost ring memory
    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[g_waddr] <= wdata;
        if (rd_op && (cmd.q == Q_GHOST))
            rd_g_reg <= g_mem[g_raddr];
    end

    // working registers of the current transaction
    always_ff @(posedge clk)
    begin
        if (rd_op)
            rd_q_reg <= cmd.q;
        if (cmd.ev_begin)
            before_reg <= total;
        case (cmd.op)
            OP_LATCH:
            begin
                kind_reg <= req_kind;
                key_reg <= req_key;
                size_reg <= req_size;
                gh_reg <= 1'b0;
                res_present_reg <= 1'b0;
                res_ghost_reg <= 1'b0;
                res_admitted_reg <= 1'b0;
                res_main_reg <= 1'b0;
                res_removed_reg <= 1'b0;
            end
            OP_FIND_INIT:
            begin
                fkey_reg <= key_reg;
                idx_reg <= '0;
            end
            OP_FIND_INIT_CUR:
            begin
                fkey_reg <= cur_reg.key;
                idx_reg <= '0;
            end
            OP_IDX_INC, OP_REM_SHIFT:
            begin
                idx_reg <= idx1[IDX_W-1:0];
            end
            OP_POP:
            begin
                if (cmd.q == Q_SMALL)
                    cur_reg <= rd_slot;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (cmd.set_present)
            res_present_reg <= 1'b1;
        if (cmd.set_ghost)
        begin
            res_ghost_reg <= 1'b1;
            gh_reg <= 1'b1;
        end
        if (cmd.set_removed)
            res_removed_reg <= 1'b1;
        if (cmd.do_insert && !dq_full)
        begin
            res_admitted_reg <= 1'b1;
            res_main_reg <= dq_main;
        end
    end

    // ring pointers and byte occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_head_reg <= '0;
            m_head_reg <= '0;
            g_head_reg <= '0;
            s_cnt_reg <= '0;
            m_cnt_reg <= '0;
            g_cnt_reg <= '0;
            s_occ_reg <= '0;
            m_occ_reg <= '0;
            g_occ_reg <= '0;
            ev_once_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_insert && !dq_full)
            begin
                if (dq_main)
                begin
                    m_cnt_reg <= m_cnt_reg + M_CW'(1);
                    m_occ_reg <= m_occ_reg + OCC_W'(size_reg);
                end
                else
                begin
                    s_cnt_reg <= s_cnt_reg + S_CW'(1);
                    s_occ_reg <= s_occ_reg + OCC_W'(size_reg);
                end
            end
            case (cmd.op)
                OP_REM_SUB:
                begin
                    case (cmd.q)
                        Q_SMALL: s_occ_reg <= s_occ_reg - OCC_W'(rd_slot.size);
                        Q_MAIN:  m_occ_reg <= m_occ_reg - OCC_W'(rd_slot.size);
                        default: g_occ_reg <= g_occ_reg - OCC_W'(rd_slot.size);
                    endcase
                end
                OP_REM_END:
                begin
                    case (cmd.q)
                        Q_SMALL: s_cnt_reg <= s_cnt_reg - S_CW'(1);
                        Q_MAIN:  m_cnt_reg <= m_cnt_reg - M_CW'(1);
                        default: g_cnt_reg <= g_cnt_reg - G_CW'(1);
                    endcase
                end
                OP_POP:
                begin
                    case (cmd.q)
                        Q_SMALL:
                        begin
                            s_occ_reg <= s_occ_reg - OCC_W'(rd_slot.size);
                            s_head_reg <= s_head_reg + S_AW'(1);
                            s_cnt_reg <= s_cnt_reg - S_CW'(1);
                        end
                        Q_MAIN:
                        begin
                            m_occ_reg <= m_occ_reg - OCC_W'(rd_slot.size);
                            m_head_reg <= m_head_reg + M_AW'(1);
                            m_cnt_reg <= m_cnt_reg - M_CW'(1);
                        end
                        default:
                        begin
                            g_occ_reg <= g_occ_reg - OCC_W'(rd_slot.size);
                            g_head_reg <= g_head_reg + G_AW'(1);
                            g_cnt_reg <= g_cnt_reg - G_CW'(1);
                        end
                    endcase
                end
                OP_POP_PROMOTE:
                begin
                    s_occ_reg <= s_occ_reg - OCC_W'(rd_slot.size);
                    s_head_reg <= s_head_reg + S_AW'(1);
                    s_cnt_reg <= s_cnt_reg - S_CW'(1);
                    m_occ_reg <= m_occ_reg + OCC_W'(rd_slot.size);
                    m_cnt_reg <= m_cnt_reg + M_CW'(1);
                end
                OP_ROTATE_M:
                begin
                    m_head_reg <= m_head_reg + M_AW'(1);
                end
                OP_GPUSH:
                begin
                    g_occ_reg <= g_occ_reg + OCC_W'(cur_reg.size);
                    g_cnt_reg <= g_cnt_reg + G_CW'(1);
                end
                default:
                begin
                    ev_once_reg <= ev_once_reg || cmd.ev_mark;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_cap_reg <= SMALL_CAP_RST;
            m_cap_reg <= MAIN_CAP_RST;
            g_cap_reg <= GHOST_CAP_RST;
            thr_reg <= PROMOTE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SMALL_CAP: s_cap_reg <= cfg_data[CAP_W-1:0];
                CFG_MAIN_CAP:  m_cap_reg <= cfg_data[CAP_W-1:0];
                CFG_GHOST_CAP: g_cap_reg <= cfg_data[CAP_W-1:0];
                default:       thr_reg <= cfg_data[FREQ_W-1:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (rsp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_present_reg <= res_present_reg;
            out_ghost_reg <= res_ghost_reg;
            out_admitted_reg <= res_admitted_reg;
            out_main_reg <= res_main_reg;
            out_removed_reg <= res_removed_reg;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_present = out_present_reg;
    assign rsp_ghost_seen = out_ghost_reg;
    assign rsp_admitted = out_admitted_reg;
    assign rsp_placed_main = out_main_reg;
    assign rsp_was_removed = out_removed_reg;

    // status towards the controller
    always_comb
    begin
        st.kind = kind_reg;
        st.match = (rd_slot.key == fkey_reg);
        st.idx_lt[Q_SMALL] = (idx_reg < IDX_W'(s_cnt_reg));
        st.idx_lt[Q_MAIN] = (idx_reg < IDX_W'(m_cnt_reg));
        st.idx_lt[Q_GHOST] = (idx_reg < IDX_W'(g_cnt_reg));
        st.idx1_lt[Q_SMALL] = (idx1 < (IDX_W + 1)'(s_cnt_reg));
        st.idx1_lt[Q_MAIN] = (idx1 < (IDX_W + 1)'(m_cnt_reg));
        st.idx1_lt[Q_GHOST] = (idx1 < (IDX_W + 1)'(g_cnt_reg));
        st.too_big = (size_reg == '0) || (size_reg > s_cap_reg) ||
                     ((size_reg == s_cap_reg) && !gh_reg);
        st.loop_cond = ((total + (OCC_W + 1)'(size_reg)) >
                        ((OCC_W + 1)'(s_cap_reg) + (OCC_W + 1)'(m_cap_reg))) || dq_full;
        st.total_zero = (s_cnt_reg == '0) && (m_cnt_reg == '0);
        st.ev_main_sel = (m_occ_reg > OCC_W'(m_cap_reg)) || (s_cnt_reg == '0);
        st.s_empty = (s_cnt_reg == '0);
        st.m_empty = (m_cnt_reg == '0);
        st.promote = (rd_slot.freq >= thr_reg) && !m_full;
        st.freq_nz = (rd_slot.freq != '0);
        st.ghost_skip = (g_cap_reg == '0) || (cur_reg.size > g_cap_reg);
        st.ghost_drop = (g_cnt_reg != '0) &&
                        ((({1'b0, g_occ_reg} + (OCC_W + 1)'(cur_reg.size)) >
                          (OCC_W + 1)'(g_cap_reg)) || g_full);
        st.ev_again = (total >= before_reg) &&
                      !((s_cnt_reg == '0) && (m_cnt_reg == '0));
        st.out_free = !out_valid_reg || rsp_ready;
    end

endmodule

/* hw/rtl/s3f_controller.sv */
// controller: sequences lookup, removal, eviction and insertion steps
module s3f_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  s3f_pkg::status_t   st,
    output s3f_pkg::cmd_t      cmd
);
    import s3f_pkg::*;

    state_t state_reg;
    state_t state_next;
    ctx_t   ctx_reg;
    ctx_t   ctx_next;
    q_sel_t ctx_q;

    // queue searched in each context
    always_comb
    begin
        case (ctx_reg)
            C_ACC_S, C_PEEK_S, C_REM_S: ctx_q = Q_SMALL;
            C_ACC_M, C_PEEK_M, C_REM_M: ctx_q = Q_MAIN;
            default:                    ctx_q = Q_GHOST;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ctx_reg <= C_ACC_S;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg <= ctx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ctx_next = ctx_reg;
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                    state_next = ST_DISPATCH;
            ST_DISPATCH:
            begin
                state_next = ST_F_CHK;
                case (st.kind)
                    KIND_ACCESS: ctx_next = C_ACC_S;
                    KIND_PEEK:   ctx_next = C_PEEK_S;
                    KIND_REMOVE: ctx_next = C_REM_S;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_F_CHK:
                state_next = st.idx_lt[ctx_q] ? ST_F_CMP : ST_NOTFOUND;
            ST_F_CMP:
                state_next = st.match ? ST_FOUND : ST_F_CHK;
            ST_NOTFOUND:
            begin
                state_next = ST_F_CHK;
                case (ctx_reg)
                    C_ACC_S:  ctx_next = C_ACC_G;
                    C_ACC_G:  ctx_next = C_ACC_M;
                    C_ACC_M:  state_next = ST_MISS;
                    C_PEEK_S: ctx_next = C_PEEK_M;
                    C_REM_S:  ctx_next = C_REM_G;
                    C_REM_G:  ctx_next = C_REM_M;
                    C_GPUT:   state_next = ST_GP_DROP;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_FOUND:
            begin
                case (ctx_reg)
                    C_ACC_S, C_ACC_M:            state_next = ST_BUMP;
                    C_PEEK_S, C_PEEK_M:          state_next = ST_DONE;
                    C_GPUT:                      state_next = ST_EV_END;
                    default:                     state_next = ST_R_SUB;
                endcase
            end
            ST_BUMP:
                state_next = ST_DONE;
            ST_R_SUB:
                state_next = ST_R_CHK;
            ST_R_CHK:
                state_next = st.idx1_lt[ctx_q] ? ST_R_WR : ST_R_END;
            ST_R_WR:
                state_next = ST_R_CHK;
            ST_R_END:
            begin
                if (ctx_reg == C_ACC_G)
                begin
                    ctx_next = C_ACC_M;
                    state_next = ST_F_CHK;
                end
                else
                    state_next = ST_DONE;
            end
            ST_MISS:
                state_next = st.too_big ? ST_DONE : ST_LOOP_CHK;
            ST_LOOP_CHK:
                state_next = (st.loop_cond && !st.total_zero) ? ST_EV_START : ST_INSERT;
            ST_EV_START:
                state_next = ST_EV_ONCE;
            ST_EV_ONCE:
                state_next = st.ev_main_sel ? ST_EM_LOOP : ST_ES_LOOP;
            ST_EM_LOOP:
                state_next = st.m_empty ? ST_EV_END : ST_EM_POP;
            ST_EM_POP:
                state_next = st.freq_nz ? ST_EM_LOOP : ST_EV_END;
            ST_ES_LOOP:
                state_next = st.s_empty ? ST_EV_END : ST_ES_POP;
            ST_ES_POP:
                state_next = st.promote ? ST_ES_LOOP : ST_GP_START;
            ST_GP_START:
            begin
                if (st.ghost_skip)
                    state_next = ST_EV_END;
                else
                begin
                    ctx_next = C_GPUT;
                    state_next = ST_F_CHK;
                end
            end
            ST_GP_DROP:
                state_next = st.ghost_drop ? ST_GP_POPG : ST_GP_PUSH;
            ST_GP_POPG:
                state_next = ST_GP_DROP;
            ST_GP_PUSH:
                state_next = ST_EV_END;
            ST_EV_END:
                state_next = st.ev_again ? ST_EV_ONCE : ST_LOOP_CHK;
            ST_INSERT:
                state_next = ST_DONE;
            ST_DONE:
                if (st.out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '{op: OP_NONE, q: ctx_q, set_present: 1'b0, set_ghost: 1'b0,
                set_removed: 1'b0, do_insert: 1'b0, ev_begin: 1'b0, ev_mark: 1'b0,
                load_out: 1'b0};
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    cmd.op = OP_LATCH;
            end
            ST_DISPATCH:
                cmd.op = OP_FIND_INIT;
            ST_F_CHK:
                if (st.idx_lt[ctx_q])
                    cmd.op = OP_READ_IDX;
            ST_F_CMP:
                if (!st.match)
                    cmd.op = OP_IDX_INC;
            ST_NOTFOUND:
                cmd.op = OP_FIND_INIT;
            ST_FOUND:
            begin
                case (ctx_reg)
                    C_ACC_G:
                        cmd.set_ghost = 1'b1;
                    C_PEEK_S, C_PEEK_M:
                        cmd.set_present = 1'b1;
                    C_REM_S, C_REM_M:
                    begin
                        cmd.set_present = 1'b1;
                        cmd.set_removed = 1'b1;
                    end
                    C_REM_G:
                    begin
                        cmd.set_ghost = 1'b1;
                        cmd.set_removed = 1'b1;
                    end
                    default:
                        cmd.op = OP_NONE;
                endcase
            end
            ST_BUMP:
            begin
                cmd.op = OP_BUMP;
                cmd.set_present = 1'b1;
            end
            ST_R_SUB:
                cmd.op = OP_REM_SUB;
            ST_R_CHK:
                cmd.op = st.idx1_lt[ctx_q] ? OP_READ_IDX1 : OP_REM_END;
            ST_R_WR:
                cmd.op = OP_REM_SHIFT;
            ST_R_END:
                cmd.op = OP_FIND_INIT;
            ST_EV_START:
                cmd.ev_begin = 1'b1;
            ST_EV_ONCE:
                cmd.ev_mark = 1'b1;
            ST_EM_LOOP:
            begin
                cmd.q = Q_MAIN;
                if (!st.m_empty)
                    cmd.op = OP_READ_HEAD;
            end
            ST_EM_POP:
            begin
                cmd.q = Q_MAIN;
                cmd.op = st.freq_nz ? OP_ROTATE_M : OP_POP;
            end
            ST_ES_LOOP:
            begin
                cmd.q = Q_SMALL;
                if (!st.s_empty)
                    cmd.op = OP_READ_HEAD;
            end
            ST_ES_POP:
            begin
                cmd.q = Q_SMALL;
                cmd.op = st.promote ? OP_POP_PROMOTE : OP_POP;
            end
            ST_GP_START:
                cmd.op = OP_FIND_INIT_CUR;
            ST_GP_DROP:
            begin
                cmd.q = Q_GHOST;
                if (st.ghost_drop)
                    cmd.op = OP_READ_HEAD;
            end
            ST_GP_POPG:
            begin
                cmd.q = Q_GHOST;
                cmd.op = OP_POP;
            end
            ST_GP_PUSH:
            begin
                cmd.q = Q_GHOST;
                cmd.op = OP_GPUSH;
            end
            ST_INSERT:
                cmd.do_insert = 1'b1;
            ST_DONE:
                cmd.load_out = st.out_free;
            default:
                cmd.op = OP_NONE;
        endcase
    end

endmodule

/* hw/rtl/s3f_checker.sv */
// port-level checker for the s3-fifo replacement engine and its bind
module s3f_checker (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic present,
    input logic ghost_seen,
    input logic admitted,
    input logic placed_main,
    input logic was_removed
);

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid &&
        $stable({present, ghost_seen, admitted, placed_main, was_removed}))
        else $error("result changed while stalled");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // a removal reports where the key was
    a_removed_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && was_removed |-> present || ghost_seen)
        else $error("removal without a found key");

    // insertion flags are consistent with a miss
    a_admit_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (admitted || placed_main) |-> admitted && !present && !was_removed)
        else $error("insertion flags inconsistent");

endmodule

bind s3fifo_replacement_policy_unit s3f_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .present     (rsp.present),
    .ghost_seen  (rsp.ghost_seen),
    .admitted    (rsp.admitted),
    .placed_main (rsp.placed_main),
    .was_removed (rsp.was_removed)
);

/* tb/s3f_tb_if.sv */
// testbench package: request and result transaction types
`timescale 1ns / 100ps
package s3f_tb_pkg;
    // kind code outside the defined set
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

    // request transaction as the stimulus queue holds it
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic [15:0] size;
    } req_item_t;

    // result transaction as predicted and observed
    typedef struct packed {
        logic present;
        logic ghost_seen;
        logic admitted;
        logic placed_main;
        logic was_removed;
    } rsp_item_t;
endpackage

/* tb/s3fifo_replacement_policy_unit_tb.sv */
// self-checking testbench of the s3-fifo replacement engine with a behavioural cache model
`timescale 1ns / 100ps
module s3fifo_replacement_policy_unit_tb;
    import s3f_pkg::*;
    import s3f_tb_pkg::*;

    typedef struct {
        logic [31:0] key;
        int unsigned size;
        int unsigned freq;
    } entry_t;

    logic clk;
    logic rst_n;
    int   n_fail;
    int   n_checked;
    int   n_sent;

    s3f_req_if req ();
    s3f_rsp_if rsp ();
    s3f_cfg_if cfg ();

    s3fifo_replacement_policy_unit dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source),
        .cfg  (cfg.sink)
    );

    // model state: queues hold entries head first
    entry_t      small_q[$];
    entry_t      main_q[$];
    entry_t      ghost_q[$];
    int unsigned occ_small, occ_main, occ_ghost;
    bit          evict_seen;
    int unsigned cap_small, cap_main, cap_ghost, promote_lvl;

    req_item_t   pending_reqs[$];
    rsp_item_t   expected_rsps[$];

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int find_key(ref entry_t q[$], input logic [31:0] key);
        foreach (q[i])
            if (q[i].key == key)
                return i;
        return -1;
    endfunction

    function automatic void ghost_insert(entry_t e);
        if (cap_ghost == 0 || e.size > cap_ghost)
            return;
        if (find_key(ghost_q, e.key) >= 0)
            return;
        while (ghost_q.size() > 0 &&
               (occ_ghost + e.size > cap_ghost || ghost_q.size() >= GRING_DEPTH))
        begin
            occ_ghost -= ghost_q[0].size;
            void'(ghost_q.pop_front());
        end
        e.freq = 0;
        ghost_q.push_back(e);
        occ_ghost += e.size;
    endfunction

    function automatic void evict_small_pass();
        entry_t e;
        while (small_q.size() > 0)
        begin
            e = small_q.pop_front();
            occ_small -= e.size;
            if (e.freq >= promote_lvl && main_q.size() < MAIN_DEPTH)
            begin
                e.freq = 0;
                main_q.push_back(e);
                occ_main += e.size;
            end
            else
            begin
                ghost_insert(e);
                return;
            end
        end
    endfunction

    function automatic void evict_main_pass();
        entry_t e;
        while (main_q.size() > 0)
        begin
            e = main_q.pop_front();
            if (e.freq >= 1)
            begin
                e.freq -= 1;
                main_q.push_back(e);
            end
            else
            begin
                occ_main -= e.size;
                return;
            end
        end
    endfunction

    // one eviction: passes until the cached byte total drops or the cache is empty
    function automatic void evict_cached();
        int unsigned total_at_start;
        total_at_start = occ_small + occ_main;
        do
        begin
            evict_seen = 1'b1;
            if (occ_main > cap_main || small_q.size() == 0)
                evict_main_pass();
            else
                evict_small_pass();
        end
        while (occ_small + occ_main >= total_at_start && small_q.size() + main_q.size() > 0);
    endfunction

    function automatic bit goes_to_main(bit ghost_hit);
        if (ghost_hit)
            return 1'b1;
        return !evict_seen && occ_small >= cap_small;
    endfunction

    function automatic bit dest_full(bit ghost_hit);
        if (goes_to_main(ghost_hit))
            return main_q.size() >= MAIN_DEPTH;
        return small_q.size() >= SMALL_DEPTH;
    endfunction

    // expected outcome of one request, updating the cache model
    function automatic rsp_item_t cache_outcome(req_item_t it);
        rsp_item_t r;
        int        i;
        bit        ghost_hit;
        entry_t    e;
        r = '0;
        ghost_hit = 1'b0;
        case (it.kind)
            KIND_ACCESS:
            begin
                i = find_key(small_q, it.key);
                if (i >= 0)
                begin
                    if (small_q[i].freq < 3)
                        small_q[i].freq += 1;
                    r.present = 1'b1;
                    return r;
                end
                i = find_key(ghost_q, it.key);
                if (i >= 0)
                begin
                    occ_ghost -= ghost_q[i].size;
                    ghost_q.delete(i);
                    ghost_hit = 1'b1;
                    r.ghost_seen = 1'b1;
                end
                i = find_key(main_q, it.key);
                if (i >= 0)
                begin
                    if (main_q[i].freq < 3)
                        main_q[i].freq += 1;
                    r.present = 1'b1;
                    return r;
                end
                if (it.size == 0 || it.size > cap_small ||
                    (it.size == cap_small && !ghost_hit))
                    return r;
                while (occ_small + occ_main + it.size > cap_small + cap_main ||
                       dest_full(ghost_hit))
                begin
                    if (small_q.size() + main_q.size() == 0)
                        break;
                    evict_cached();
                end
                if (dest_full(ghost_hit))
                    return r;
                e.key = it.key;
                e.size = it.size;
                e.freq = 0;
                r.admitted = 1'b1;
                if (goes_to_main(ghost_hit))
                begin
                    main_q.push_back(e);
                    occ_main += e.size;
                    r.placed_main = 1'b1;
                end
                else
                begin
                    small_q.push_back(e);
                    occ_small += e.size;
                end
            end
            KIND_PEEK:
                r.present = find_key(small_q, it.key) >= 0 || find_key(main_q, it.key) >= 0;
            KIND_REMOVE:
            begin
                i = find_key(small_q, it.key);
                if (i >= 0)
                begin
                    occ_small -= small_q[i].size;
                    small_q.delete(i);
                    r.present = 1'b1;
                    r.was_removed = 1'b1;
                    return r;
                end
                i = find_key(ghost_q, it.key);
                if (i >= 0)
                begin
                    occ_ghost -= ghost_q[i].size;
                    ghost_q.delete(i);
                    r.ghost_seen = 1'b1;
                    r.was_removed = 1'b1;
                    return r;
                end
                i = find_key(main_q, it.key);
                if (i >= 0)
                begin
                    occ_main -= main_q[i].size;
                    main_q.delete(i);
                    r.present = 1'b1;
                    r.was_removed = 1'b1;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // request driver: bursts with random gaps
    int burst_left;
    int gap_left;
    int n_driven;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.kind <= '0;
            req.object_key <= '0;
            req.object_size <= '0;
            burst_left <= 0;
            gap_left <= 0;
            n_driven <= 0;
        end
        else if (req.valid && (n_sent < n_driven))
        begin
            // hold the offered transaction
        end
        else if (gap_left > 0)
        begin
            req.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_reqs.size() > 0)
        begin
            req.valid <= 1'b1;
            req.kind <= pending_reqs[0].kind;
            req.object_key <= pending_reqs[0].key;
            req.object_size <= pending_reqs[0].size;
            void'(pending_reqs.pop_front());
            n_driven <= n_driven + 1;
            if (burst_left <= 0)
            begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
            end
            else
                burst_left <= burst_left - 1;
        end
        else
            req.valid <= 1'b0;
    end

    // request acceptance feeds the model
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            expected_rsps.push_back(cache_outcome('{req.kind, req.object_key,
                                                    req.object_size}));
            n_sent++;
        end
    end

    // result receiver stall pattern
    int stall_phase;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9])
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result monitor
    rsp_item_t want;
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("result transaction with nothing expected");
                n_fail++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                n_checked++;
                if (rsp.present !== want.present)
                begin
                    $error("present: expected %0b actual %0b", want.present, rsp.present);
                    n_fail++;
                end
                if (rsp.ghost_seen !== want.ghost_seen)
                begin
                    $error("ghost_seen: expected %0b actual %0b", want.ghost_seen,
                           rsp.ghost_seen);
                    n_fail++;
                end
                if (rsp.admitted !== want.admitted)
                begin
                    $error("admitted: expected %0b actual %0b", want.admitted, rsp.admitted);
                    n_fail++;
                end
                if (rsp.placed_main !== want.placed_main)
                begin
                    $error("placed_main: expected %0b actual %0b", want.placed_main,
                           rsp.placed_main);
                    n_fail++;
                end
                if (rsp.was_removed !== want.was_removed)
                begin
                    $error("was_removed: expected %0b actual %0b", want.was_removed,
                           rsp.was_removed);
                    n_fail++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val[15:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            CFG_SMALL_CAP: cap_small = val & 16'hFFFF;
            CFG_MAIN_CAP:  cap_main = val & 16'hFFFF;
            CFG_GHOST_CAP: cap_ghost = val & 16'hFFFF;
            default:       promote_lvl = val & 3;
        endcase
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
    endtask

    function automatic void add_req(logic [1:0] kind, logic [31:0] key, logic [15:0] size);
        pending_reqs.push_back('{kind, key, size});
    endfunction

    // random phase: small key pool so hits, ghost hits and evictions are common
    task automatic random_phase(int count, int unsigned key_pool, int unsigned max_size);
        int          r;
        logic [31:0] key;
        logic [15:0] size;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            key = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, key_pool);
            size = ($urandom_range(0, 29) == 0) ? $urandom : $urandom_range(1, max_size);
            if (r < 70)
                add_req(KIND_ACCESS, key, size);
            else if (r < 82)
                add_req(KIND_PEEK, key, size);
            else if (r < 96)
                add_req(KIND_REMOVE, key, size);
            else
                add_req(KIND_UNKNOWN, key, size);
        end
    endtask

    // stimulus and configuration phases
    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        n_fail = 0;
        n_checked = 0;
        n_sent = 0;
        evict_seen = 1'b0;
        occ_small = 0;
        occ_main = 0;
        occ_ghost = 0;
        cap_small = SMALL_CAP_RST;
        cap_main = MAIN_CAP_RST;
        cap_ghost = GHOST_CAP_RST;
        promote_lvl = PROMOTE_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first-fill to main, oversize, hits, peek, remove, unknown kind, then evictions
        add_req(KIND_ACCESS, 32'd1, 16'd60);
        add_req(KIND_ACCESS, 32'd2, 16'd50);
        add_req(KIND_ACCESS, 32'd3, 16'd40);
        add_req(KIND_ACCESS, 32'd1, 16'd60);
        add_req(KIND_ACCESS, 32'd1, 16'd60);
        add_req(KIND_ACCESS, 32'd1, 16'd60);
        add_req(KIND_ACCESS, 32'd1, 16'd60);
        add_req(KIND_ACCESS, 32'hFFFF_FFFF, 16'd100);
        add_req(KIND_ACCESS, 32'd4, 16'hFFFF);
        add_req(KIND_ACCESS, 32'd5, 16'd0);
        add_req(KIND_PEEK, 32'd2, 16'd1);
        add_req(KIND_PEEK, 32'd77, 16'd1);
        add_req(KIND_REMOVE, 32'd3, 16'd1);
        add_req(KIND_REMOVE, 32'd99, 16'd1);
        add_req(KIND_UNKNOWN, 32'd1, 16'd1);
        for (int k = 10; k < 22; k++)
            add_req(KIND_ACCESS, k, 16'd90);
        add_req(KIND_ACCESS, 32'd10, 16'd90);
        add_req(KIND_REMOVE, 32'd11, 16'd90);
        wait_idle();

        random_phase(350, 60, 60);
        wait_idle();
        write_reg(CFG_SMALL_CAP, 1);
        write_reg(CFG_MAIN_CAP, 1);
        write_reg(CFG_GHOST_CAP, 0);
        write_reg(CFG_PROMOTE, 0);
        random_phase(200, 20, 2);
        wait_idle();
        write_reg(CFG_SMALL_CAP, 400);
        write_reg(CFG_MAIN_CAP, 2000);
        write_reg(CFG_GHOST_CAP, 30);
        write_reg(CFG_PROMOTE, 3);
        random_phase(350, 150, 40);
        wait_idle();
        write_reg(CFG_SMALL_CAP, 65535);
        write_reg(CFG_MAIN_CAP, 65535);
        write_reg(CFG_GHOST_CAP, 65535);
        write_reg(CFG_PROMOTE, 1);
        random_phase(350, 400, 3000);
        wait_idle();
        write_reg(CFG_SMALL_CAP, 50);
        write_reg(CFG_MAIN_CAP, 300);
        write_reg(CFG_GHOST_CAP, 500);
        write_reg(CFG_PROMOTE, 2);
        random_phase(350, 40, 50);
        wait_idle();

        $display("run covered %0d requests and %0d checked results over five settings",
                 n_sent, n_checked);
        if (n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end
endmodule

/* files.f */
hw/rtl/s3f_pkg.sv
hw/rtl/s3f_req_if.sv
hw/rtl/s3f_rsp_if.sv
hw/rtl/s3f_cfg_if.sv
hw/rtl/s3f_datapath.sv
hw/rtl/s3f_controller.sv
hw/rtl/s3fifo_replacement_policy_unit.sv
hw/rtl/s3f_checker.sv
tb/s3f_tb_if.sv
tb/s3fifo_replacement_policy_unit_tb.sv
